@@ rtl/core/lrc_pkg.sv @@
package lrc_pkg;

    localparam int unsigned SECONDS_W     = 13;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned STAMP_CHARS   = 5;
    localparam int unsigned MAX_LYRIC_CHARS = 32;

    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3a;
    localparam logic [BYTE_W-1:0] CHAR_OPEN   = 8'h5b;
    localparam logic [BYTE_W-1:0] CHAR_CLOSE  = 8'h5d;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LYRIC_CHARS);

    // The five characters of "MM:SS", first character at index 0.
    typedef logic [BYTE_W-1:0] stamp_t [STAMP_CHARS];

    typedef struct packed {
        logic              valid;
        logic              found;
        logic              has_char;
        logic [BYTE_W-1:0] lyric_char;
        logic              last;
        logic [LEN_W-1:0]  lyric_length;
    } result_t;

endpackage

@@ rtl/core/lrc_stamp_gen.sv @@
module lrc_stamp_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lrc_pkg::SECONDS_W-1:0]  cfg_wr_data,
    output lrc_pkg::stamp_t                stamp,
    output logic                           busy
);
    import lrc_pkg::*;

    // Reciprocal of 60 scaled by 2^19; exact for every 13-bit value.
    localparam int unsigned RECIP60_SHIFT = 19;
    localparam logic [13:0] RECIP60       = 14'd8739;
    // Reciprocal of 10 scaled by 2^11; exact below 1029.
    localparam int unsigned RECIP10_SHIFT = 11;
    localparam logic [7:0]  RECIP10       = 8'd205;

    logic [2:0]            stage_vld_reg;
    logic [26:0]           prod_reg;
    logic [SECONDS_W-1:0]  secs_reg;
    logic [7:0]            mins_reg;
    logic [5:0]            rest_reg;
    logic [3:0]            mins_tens_reg;
    logic [2:0]            rest_tens_reg;
    logic [7:0]            mins_q_reg;
    logic [5:0]            rest_q_reg;
    stamp_t                stamp_reg;

    logic [7:0]            mins_next;
    logic [SECONDS_W-1:0]  mins_x60;
    logic [5:0]            rest_next;
    logic [15:0]           mins_prod;
    logic [13:0]           rest_prod;
    logic [7:0]            mins_x10;
    logic [5:0]            rest_x10;

    always_comb begin
        mins_next = prod_reg[RECIP60_SHIFT +: 8];
        mins_x60  = (SECONDS_W'(mins_next) << 6) - (SECONDS_W'(mins_next) << 2);
        rest_next = 6'(secs_reg - mins_x60);
        mins_prod = mins_reg * RECIP10;
        rest_prod = rest_reg * RECIP10;
        mins_x10  = (8'(mins_tens_reg) << 3) + (8'(mins_tens_reg) << 1);
        rest_x10  = (6'(rest_tens_reg) << 3) + (6'(rest_tens_reg) << 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
            stamp_reg[0]  <= CHAR_ZERO;
            stamp_reg[1]  <= CHAR_ZERO;
            stamp_reg[2]  <= CHAR_COLON;
            stamp_reg[3]  <= CHAR_ZERO;
            stamp_reg[4]  <= CHAR_ZERO;
        end else begin
            stage_vld_reg <= {stage_vld_reg[1:0], cfg_wr_en};
            if (stage_vld_reg[2]) begin
                stamp_reg[0] <= CHAR_ZERO + BYTE_W'(mins_tens_reg);
                stamp_reg[1] <= CHAR_ZERO + BYTE_W'(mins_q_reg - mins_x10);
                stamp_reg[2] <= CHAR_COLON;
                stamp_reg[3] <= CHAR_ZERO + BYTE_W'(rest_tens_reg);
                stamp_reg[4] <= CHAR_ZERO + BYTE_W'(rest_q_reg - rest_x10);
            end
        end
        prod_reg      <= cfg_wr_data * RECIP60;
        secs_reg      <= cfg_wr_data;
        mins_reg      <= mins_next;
        rest_reg      <= rest_next;
        mins_tens_reg <= mins_prod[RECIP10_SHIFT +: 4];
        rest_tens_reg <= rest_prod[RECIP10_SHIFT +: 3];
        mins_q_reg    <= mins_reg;
        rest_q_reg    <= rest_reg;
    end

    assign stamp = stamp_reg;
    assign busy  = cfg_wr_en | (|stage_vld_reg);

endmodule

@@ rtl/core/lrc_scan.sv @@
module lrc_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [lrc_pkg::BYTE_W-1:0]  file_byte,
    input  logic                        end_of_file,
    input  lrc_pkg::stamp_t             stamp,
    output lrc_pkg::result_t            result
);
    import lrc_pkg::*;

    typedef enum logic [2:0] {
        MODE_SEEK,
        MODE_CMP,
        MODE_CLOSE,
        MODE_AFTER,
        MODE_COPY,
        MODE_DONE
    } mode_t;

    mode_t             mode_reg,  mode_next;
    logic [2:0]        index_reg, index_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    logic [BYTE_W-1:0] expect_char;
    logic [LEN_W-1:0]  count_base;
    logic [LEN_W-1:0]  count_inc;
    logic              copy_now;
    logic              stop;

    always_comb begin
        unique case (index_reg)
            3'd0:    expect_char = stamp[0];
            3'd1:    expect_char = stamp[1];
            3'd2:    expect_char = stamp[2];
            3'd3:    expect_char = stamp[3];
            default: expect_char = stamp[4];
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        index_next = index_reg;
        count_next = count_reg;
        result     = '0;
        copy_now   = 1'b0;
        count_base = count_reg;
        stop       = 1'b0;
        count_inc  = '0;

        unique case (mode_reg)
            MODE_SEEK: begin
                if (file_byte == CHAR_OPEN) begin
                    mode_next  = MODE_CMP;
                    index_next = '0;
                end
            end
            MODE_CMP: begin
                if (file_byte != expect_char) begin
                    mode_next  = MODE_SEEK;
                    index_next = '0;
                end else begin
                    index_next = index_reg + 3'd1;
                    if (index_next >= 3'(STAMP_CHARS)) begin
                        mode_next = MODE_CLOSE;
                    end
                end
            end
            MODE_CLOSE: begin
                if (file_byte == CHAR_CLOSE) begin
                    mode_next = MODE_AFTER;
                end
            end
            MODE_AFTER: begin
                if (file_byte == CHAR_OPEN) begin
                    mode_next = MODE_CLOSE;
                end else begin
                    copy_now   = 1'b1;
                    count_base = '0;
                end
            end
            MODE_COPY: begin
                copy_now = 1'b1;
            end
            default: begin
            end
        endcase

        if (copy_now) begin
            result.valid = 1'b1;
            result.found = 1'b1;
            result.last  = 1'b1;
            if (file_byte == CHAR_LF) begin
                result.lyric_length = count_base;
                count_next          = count_base;
                mode_next           = MODE_DONE;
            end else begin
                count_inc           = count_base + LEN_W'(1);
                stop                = end_of_file || (count_inc >= MAX_LEN);
                count_next          = count_inc;
                result.has_char     = 1'b1;
                result.lyric_char   = file_byte;
                result.last         = stop;
                result.lyric_length = count_inc;
                mode_next           = stop ? MODE_DONE : MODE_COPY;
            end
        end

        if (end_of_file) begin
            if (!copy_now && (mode_next != MODE_DONE)) begin
                result.valid = 1'b1;
                result.last  = 1'b1;
            end
            mode_next  = MODE_SEEK;
            index_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SEEK;
            index_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            index_reg <= index_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/lrc_timestamp_lyric_extract_top.sv @@
// An accepted input transaction has its result on the m_ side in the next cycle.
// Throughput: one byte per cycle while no configuration write runs and results are
// drained, set by the scan state update and the one-entry result register, which is
// refilled in the cycle it is drained. A configuration write holds s_tready low while
// the stamp converter recomputes. Reset (aresetn low, synchronous) clears the scan
// state, empties the result register and sets the sought time to 00:00.
module lrc_timestamp_lyric_extract_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Play time in seconds; written while the block is idle.
    input  logic                           cfg_wr_en,
    input  logic [lrc_pkg::SECONDS_W-1:0]  cfg_wr_data,

    // Input stream, one file byte per transaction.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] file_byte
    input  logic                           s_tlast,   // end_of_file

    // Result stream, at most one result per input byte.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [0] found, [1] has_char,
                                                      // [9:2] lyric_char,
                                                      // [15:10] lyric_length
    output logic                           m_tlast    // last
);
    import lrc_pkg::*;

    stamp_t   stamp;
    logic     stamp_busy;
    result_t  scan_result;
    logic     in_accept;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic                 out_has_char_reg;
    logic [BYTE_W-1:0]    out_char_reg;
    logic                 out_last_reg;
    logic [LEN_W-1:0]     out_len_reg;

    // The stamp converter turns the written seconds into the five "MM:SS"
    // characters over a short pipeline, so no divider sits in the byte path.
    lrc_stamp_gen u_stamp_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stamp       (stamp),
        .busy        (stamp_busy)
    );

    // A new byte is taken whenever the stamp converter is idle and the result
    // register is empty or is being drained in this cycle, so the scanner never
    // waits on a pending result that the consumer is about to take.
    assign s_tready  = !stamp_busy && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    lrc_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .file_byte   (s_tdata),
        .end_of_file (s_tlast),
        .stamp       (stamp),
        .result      (scan_result)
    );

    // Result register. It loads on every accepted transaction; a byte that
    // produces no result simply leaves it empty once the old result is gone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= scan_result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_accept) begin
            out_found_reg    <= scan_result.found;
            out_has_char_reg <= scan_result.has_char;
            out_char_reg     <= scan_result.lyric_char;
            out_last_reg     <= scan_result.last;
            out_len_reg      <= scan_result.lyric_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_char_reg, out_has_char_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/tb.sv @@
module tb;

    import lrc_pkg::*;

    // Cycles without any transaction on either side before the run is declared hung.
    // The longest correct quiet stretch is the receiver's long hold-off plus a
    // sender gap, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 3000;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int LONG_HOLD = 120;
    localparam int TARGET_ITEMS = 1800;
    localparam int PHASE_ITEMS = 300;

    // Scan modes of the lookup, in the order a matching file walks through them.
    typedef enum logic [2:0] {
        SCAN_SEEK,
        SCAN_CMP,
        SCAN_CLOSE,
        SCAN_AFTER,
        SCAN_COPY,
        SCAN_DONE
    } scan_mode_e;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic              found;
        logic              has_char;
        logic [BYTE_W-1:0] lyric_char;
        logic              is_last;
        logic [LEN_W-1:0]  lyric_length;
    } lyric_beat_t;

    // The tracker follows the search through the file, one accepted byte at a time,
    // and keeps the results the block owes in arrival order.
    class lyric_tracker;
        logic [SECONDS_W-1:0] seconds;
        scan_mode_e           mode;
        int                   match_idx;
        logic [LEN_W-1:0]     copied;
        lyric_beat_t          awaited_beats[$];
        int                   errors;

        function new();
            seconds = '0;
            errors = 0;
            clear_search();
        endfunction

        function void clear_search();
            mode = SCAN_SEEK;
            match_idx = 0;
            copied = '0;
        endfunction

        // Character number pos of the MM:SS stamp for the current play time. The
        // tens of minutes are not limited to a digit, so times past 99 minutes give
        // whatever character follows '9'.
        function logic [BYTE_W-1:0] stamp_at(int pos);
            int unsigned mins;
            int unsigned rest;
            mins = seconds / 60;
            rest = seconds % 60;
            case (pos)
                0: return BYTE_W'(mins / 10) + CHAR_ZERO;
                1: return BYTE_W'(mins % 10) + CHAR_ZERO;
                2: return CHAR_COLON;
                3: return BYTE_W'(rest / 10) + CHAR_ZERO;
                default: return BYTE_W'(rest % 10) + CHAR_ZERO;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, bit eof);
            lyric_beat_t beat;
            bit          emitted;
            bit          stop_now;
            emitted = 0;
            beat = '0;
            case (mode)
                SCAN_SEEK: begin
                    if (b == CHAR_OPEN) begin
                        mode = SCAN_CMP;
                        match_idx = 0;
                    end
                end
                SCAN_CMP: begin
                    // A failing byte is dropped, even when it is itself a '['.
                    if (b != stamp_at(match_idx)) begin
                        mode = SCAN_SEEK;
                        match_idx = 0;
                    end else begin
                        match_idx++;
                        if (match_idx >= STAMP_CHARS) begin
                            mode = SCAN_CLOSE;
                        end
                    end
                end
                SCAN_CLOSE: begin
                    if (b == CHAR_CLOSE) begin
                        mode = SCAN_AFTER;
                    end
                end
                SCAN_AFTER, SCAN_COPY: begin
                    if (mode == SCAN_AFTER && b == CHAR_OPEN) begin
                        // Another tag stacked behind the matching one.
                        mode = SCAN_CLOSE;
                    end else begin
                        if (mode == SCAN_AFTER) begin
                            mode = SCAN_COPY;
                            copied = '0;
                        end
                        if (b == CHAR_LF) begin
                            beat = '{1'b1, 1'b0, '0, 1'b1, copied};
                            mode = SCAN_DONE;
                        end else begin
                            copied++;
                            stop_now = eof || copied >= MAX_LEN;
                            beat = '{1'b1, 1'b1, b, stop_now, copied};
                            if (stop_now) begin
                                mode = SCAN_DONE;
                            end
                        end
                        emitted = 1;
                    end
                end
                default: ;
            endcase
            if (eof) begin
                // The file ended before any lyric came out: report it as not found.
                if (!emitted && mode != SCAN_DONE) begin
                    beat = '{1'b0, 1'b0, '0, 1'b1, '0};
                    emitted = 1;
                end
                clear_search();
            end
            if (emitted) begin
                awaited_beats.push_back(beat);
            end
        endfunction

        function void check_beat(logic [15:0] data, logic tlast);
            lyric_beat_t want;
            if (awaited_beats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h last %b",
                         $time, data, tlast);
                errors++;
                return;
            end
            want = awaited_beats.pop_front();
            if (data[0] !== want.found) begin
                $display("%0t: found mismatch, expected %b, actual %b",
                         $time, want.found, data[0]);
                errors++;
            end
            if (data[1] !== want.has_char) begin
                $display("%0t: has_char mismatch, expected %b, actual %b",
                         $time, want.has_char, data[1]);
                errors++;
            end
            if (data[9:2] !== want.lyric_char) begin
                $display("%0t: lyric_char mismatch, expected %h, actual %h",
                         $time, want.lyric_char, data[9:2]);
                errors++;
            end
            if (tlast !== want.is_last) begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, want.is_last, tlast);
                errors++;
            end
            if (data[15:10] !== want.lyric_length) begin
                $display("%0t: lyric_length mismatch, expected %0d, actual %0d",
                         $time, want.lyric_length, data[15:10]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [SECONDS_W-1:0]  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tlast;

    lyric_tracker tracker;
    int           items_sent = 0;
    int           idle_cycles = 0;
    bit           long_hold_req = 0;
    bit           rx_steady = 0;
    int           hold_left = 0;

    lrc_timestamp_lyric_extract_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic void append_text(ref logic [7:0] f[$], input string s);
        for (int i = 0; i < s.len(); i++) begin
            f.push_back(s[i]);
        end
    endfunction

    // Builds one lyric file. Most lines are tag lines in the style of "[MM:SS.xx]text\n",
    // some carrying the sought stamp, some another time, some breaking off partway
    // through the stamp; the rest is raw noise. A few files are cut short at a random
    // byte, so that the end of file can land inside a tag or a lyric.
    function automatic void build_file(ref logic [7:0] f[$], input bit force_match);
        int lines;
        int kind;
        int n;
        int secs;
        int roll;
        f.delete();
        lines = force_match ? 1 : $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            kind = force_match ? 0 : $urandom_range(0, 99);
            if (kind < 80) begin
                f.push_back(CHAR_OPEN);
                if (kind < 45) begin
                    for (int i = 0; i < STAMP_CHARS; i++) begin
                        f.push_back(tracker.stamp_at(i));
                    end
                end else if (kind < 65) begin
                    secs = $urandom_range(0, 5999);
                    append_text(f, $sformatf("%02d:%02d", secs / 60, secs % 60));
                end else begin
                    // Stamp that agrees for a while and then fails, sometimes on a '['.
                    n = $urandom_range(0, STAMP_CHARS - 1);
                    for (int i = 0; i < n; i++) begin
                        f.push_back(tracker.stamp_at(i));
                    end
                    f.push_back($urandom_range(0, 1) ? CHAR_OPEN : 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 1)) begin
                    append_text(f, $sformatf(".%02d", $urandom_range(0, 99)));
                end
                if (force_match || $urandom_range(0, 9) != 0) begin
                    f.push_back(CHAR_CLOSE);
                end
                n = $urandom_range(0, 5);
                for (int i = 0; i < n && n <= 2; i++) begin
                    if ($urandom_range(0, 1)) begin
                        append_text(f, "[ar:tb]");
                    end else begin
                        append_text(f, "[]");
                    end
                end
                roll = $urandom_range(0, 99);
                if (force_match) begin
                    n = 40;
                end else if (roll < 70) begin
                    n = $urandom_range(0, 20);
                end else if (roll < 90) begin
                    n = $urandom_range(21, 31);
                end else begin
                    n = $urandom_range(32, 45);
                end
                for (int i = 0; i < n; i++) begin
                    f.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(128, 255))
                                                             : 8'($urandom_range(32, 126)));
                end
                if ($urandom_range(0, 4) != 0) begin
                    f.push_back(CHAR_LF);
                end
            end else begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    f.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        if (!force_match && $urandom_range(0, 9) == 0 && f.size() > 1) begin
            n = $urandom_range(1, f.size() - 1);
            while (f.size() > n) begin
                void'(f.pop_back());
            end
        end
    endfunction

    // Offers one byte and returns at the falling edge after it was taken. The valid
    // stays high on return, so back-to-back bytes never see it dropped in between.
    task automatic push_byte(input logic [7:0] b, input bit eof, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eof;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        tracker.take_byte(b, eof);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_file(ref logic [7:0] f[$], input bit burst);
        for (int i = 0; i < f.size(); i++) begin
            push_byte(f[i], i == f.size() - 1, burst);
        end
    endtask

    // Stops offering, waits for every owed result, then lets the block settle,
    // since a byte that produces nothing may still be in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.awaited_beats.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_seconds(input logic [SECONDS_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.seconds = value;
    endtask

    // Receiver: random stalls with stretches of steady readiness, plus one long
    // hold-off on request so that the result register fills and s_tready drops.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < 3) begin
                rx_steady = !rx_steady;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                if (hold_left > 0) begin
                    hold_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Every result transaction is checked against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_beat(m_tdata, m_tlast);
        end
    end

    // The watchdog restarts whenever either side completes a transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [7:0] file_bytes[$];
        logic [SECONDS_W-1:0] next_seconds;
        int phase;
        int phase_start;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        tracker = new();

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed files, searched with the reset time of 00:00. The first has a
        // stacked empty tag and ends in the middle of its lyric.
        file_bytes.delete();
        append_text(file_bytes, "[00:00][]A");
        send_file(file_bytes, 1'b0);
        // A stamp that fails on a '[': that bracket is dropped, so the real stamp
        // behind it is never seen and the file ends as not found.
        file_bytes = {8'hff};
        append_text(file_bytes, "[0[00:00]\n");
        send_file(file_bytes, 1'b0);
        // An empty lyric ends at once on the line feed; the byte after it is ignored.
        file_bytes.delete();
        append_text(file_bytes, "[00:00]\nx");
        send_file(file_bytes, 1'b0);

        // Random phases, each under its own play time. The first three cover the
        // top of the range, zero, and a time with more than 99 minutes.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            wait_idle();
            case (phase)
                0: next_seconds = SECONDS_W'(5999);
                1: next_seconds = '0;
                2: next_seconds = '1;
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        next_seconds = SECONDS_W'($urandom_range(0, 120));
                    end else begin
                        next_seconds = SECONDS_W'($urandom_range(0, 5999));
                    end
                end
            endcase
            write_seconds(next_seconds);
            phase_start = items_sent;
            if (phase == 1) begin
                // The receiver holds off while a long matching lyric streams in.
                long_hold_req = 1;
                build_file(file_bytes, 1'b1);
                send_file(file_bytes, 1'b1);
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                build_file(file_bytes, 1'b0);
                send_file(file_bytes, $urandom_range(0, 3) == 0);
            end
            phase++;
        end
        wait_idle();

        if (tracker.errors == 0 && tracker.awaited_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
